>>> src/emrg_pkg.sv
package emrg_pkg;

   localparam int MAX_COLS_DEF = 32;
   localparam int MIN_COLS     = 2;
   localparam int COLS_RESET   = 32;
   localparam int CFG_W        = 6;
   localparam int FIELD_W      = 32;
   localparam int WALL_W       = 31;
   localparam int LABEL_W_DEF  = 5;

   // Finished row handed from the sequencer to the output register.
   typedef struct packed {
      logic               done;
      logic [FIELD_W-1:0] right_walls;
      logic [FIELD_W-1:0] bottom_walls;
   } row_result_type;

endpackage

>>> src/emrg_label_mem.sv
module emrg_label_mem import emrg_pkg::*; #(
   parameter int DEPTH = MAX_COLS_DEF,
   parameter int WIDTH = LABEL_W_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] labels_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The sequencer never reads and writes the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         labels_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= labels_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/emrg_seq.sv
module emrg_seq import emrg_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           new_maze,
   input  logic                           last_row,
   input  logic [MAX_COLS-2:0]            wall_bits,
   input  logic [MAX_COLS-1:0]            down_bits,
   input  logic [$clog2(MAX_COLS+1)-1:0]  n_cols,
   input  logic                           res_ready,
   output logic                           busy,
   output row_result_type                 result
);

   localparam int LBL_W = $clog2(MAX_COLS);
   localparam int CNT_W = $clog2(MAX_COLS+1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_P1   = 2'd1;
   localparam logic [1:0] S_P2   = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                last_ff, last_in;
   logic [MAX_COLS-1:0] wall_ff, wall_in;
   logic [MAX_COLS-1:0] down_ff, down_in;
   logic [MAX_COLS-1:0] walled_ff, walled_in;
   logic                s1_vld_ff, s1_vld_in;
   logic [LBL_W-1:0]    s1_col_ff, s1_col_in;
   logic                s2_vld_ff, s2_vld_in;
   logic [LBL_W-1:0]    s2_col_ff, s2_col_in;
   logic [LBL_W-1:0]    s2_init_ff, s2_init_in;
   logic [LBL_W-1:0]    cur_g_ff, cur_g_in;
   logic [LBL_W-1:0]    rep_ff [MAX_COLS];
   logic [LBL_W-1:0]    rep_in [MAX_COLS];
   logic [LBL_W-1:0]    rm_ff [MAX_COLS];
   logic [LBL_W-1:0]    rm_in [MAX_COLS];
   logic [MAX_COLS-1:0] rmv_ff, rmv_in;
   logic [MAX_COLS-1:0] right_ff, right_in;
   logic [MAX_COLS-1:0] any_open_ff, any_open_in;
   logic [MAX_COLS-1:0] is_min_ff, is_min_in;

   logic [MAX_COLS-1:0] mask;
   logic [MAX_COLS-1:0] last_col;
   logic [MAX_COLS-1:0] opened;
   logic [MAX_COLS-1:0] fin_open;
   logic [MAX_COLS-1:0] bottom;
   logic [MAX_COLS-1:0] right;
   logic                issue;
   logic                finish;
   logic [LBL_W-1:0]    rd_data;
   logic                s1_walled;
   logic                rm_hit;
   logic [LBL_W-1:0]    p1_init;
   logic [LBL_W-1:0]    rep_addr;
   logic [LBL_W-1:0]    rep_out;
   logic [LBL_W-1:0]    bnd;
   logic                keep;
   logic                do_merge;
   logic [LBL_W-1:0]    lo;
   logic [LBL_W-1:0]    hi;
   logic                mem_wr_en;
   logic [LBL_W-1:0]    mem_wr_data;

   emrg_label_mem #(
      .DEPTH (MAX_COLS),
      .WIDTH (LBL_W)
   ) u_label_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (mem_wr_data),
      .rd_en   (issue),
      .rd_addr (cnt_ff[LBL_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      for (int k = 0; k < MAX_COLS; k++) begin
         mask[k]     = (CNT_W'(k) < n_ff);
         last_col[k] = (CNT_W'(k + 1) == n_ff);
      end
   end

   assign opened   = down_ff & mask;
   assign fin_open = opened | (is_min_ff & ~any_open_ff);
   assign bottom   = last_ff ? mask : (mask & ~fin_open);
   assign right    = (right_ff | last_col) & mask;

   assign issue  = ((state_ff == S_P1) || (state_ff == S_P2)) && (cnt_ff != n_ff);
   assign finish = (state_ff == S_FIN) && res_ready;
   assign busy   = (state_ff != S_IDLE);

   // First pass: a column that was open below inherits the first open column
   // that carried the same label in the previous row.
   assign s1_walled = walled_ff[s1_col_ff];
   assign rm_hit    = rmv_ff[rd_data];
   assign p1_init   = (s1_walled || !rm_hit) ? s1_col_ff : rm_ff[rd_data];

   // The group table has one read port, shared by both passes.
   assign rep_addr = s2_vld_ff ? s2_init_ff : rd_data;
   assign rep_out  = rep_ff[rep_addr];

   assign mem_wr_en   = s1_vld_ff;
   assign mem_wr_data = (state_ff == S_P1) ? p1_init : rep_out;

   assign bnd      = LBL_W'(s2_col_ff - 1'b1);
   assign keep     = !last_ff && wall_ff[bnd];
   assign do_merge = (s2_col_ff != '0) && !keep && (cur_g_ff != rep_out);
   assign lo       = (cur_g_ff < rep_out) ? cur_g_ff : rep_out;
   assign hi       = (cur_g_ff < rep_out) ? rep_out : cur_g_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      last_in     = last_ff;
      wall_in     = wall_ff;
      down_in     = down_ff;
      walled_in   = walled_ff;
      s1_vld_in   = issue;
      s1_col_in   = cnt_ff[LBL_W-1:0];
      s2_vld_in   = s1_vld_ff && (state_ff == S_P1);
      s2_col_in   = s1_col_ff;
      s2_init_in  = p1_init;
      cur_g_in    = cur_g_ff;
      rep_in      = rep_ff;
      rm_in       = rm_ff;
      rmv_in      = rmv_ff;
      right_in    = right_ff;
      any_open_in = any_open_ff;
      is_min_in   = is_min_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in    = S_P1;
               cnt_in      = '0;
               n_in        = n_cols;
               last_in     = last_row;
               wall_in     = {1'b0, wall_bits};
               down_in     = down_bits;
               rmv_in      = '0;
               right_in    = '0;
               any_open_in = '0;
               is_min_in   = '0;
               for (int e = 0; e < MAX_COLS; e++) begin
                  rep_in[e] = LBL_W'(e);
               end
               if (new_maze) begin
                  walled_in = '1;
               end
            end
         end
         S_P1: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!s1_vld_ff) begin
               state_in = S_P2;
               cnt_in   = '0;
            end
         end
         S_P2: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!s1_vld_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (res_ready) begin
               state_in  = S_IDLE;
               walled_in = bottom | ~mask;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (s1_vld_ff && (state_ff == S_P1) && !s1_walled && !rm_hit) begin
         rmv_in[rd_data] = 1'b1;
         rm_in[rd_data]  = s1_col_ff;
      end

      // Boundary between the previous column and this one; a merge renames
      // the larger group to the smaller one everywhere in the table.
      if (s2_vld_ff) begin
         if (do_merge) begin
            cur_g_in = lo;
            for (int e = 0; e < MAX_COLS; e++) begin
               if (rep_ff[e] == hi) begin
                  rep_in[e] = lo;
               end
            end
         end else begin
            cur_g_in = rep_out;
            if (s2_col_ff != '0) begin
               right_in[bnd] = 1'b1;
            end
         end
      end

      if (s1_vld_ff && (state_ff == S_P2)) begin
         if (opened[s1_col_ff]) begin
            any_open_in[rep_out] = 1'b1;
         end
         is_min_in[s1_col_ff] = (rep_out == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         walled_ff <= '1;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         walled_ff <= walled_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      last_ff     <= last_in;
      wall_ff     <= wall_in;
      down_ff     <= down_in;
      s1_col_ff   <= s1_col_in;
      s2_col_ff   <= s2_col_in;
      s2_init_ff  <= s2_init_in;
      cur_g_ff    <= cur_g_in;
      rep_ff      <= rep_in;
      rm_ff       <= rm_in;
      rmv_ff      <= rmv_in;
      right_ff    <= right_in;
      any_open_ff <= any_open_in;
      is_min_ff   <= is_min_in;
   end

   assign result.done         = finish;
   assign result.right_walls  = FIELD_W'(right);
   assign result.bottom_walls = FIELD_W'(bottom);

endmodule

>>> src/eller_maze_row_generator.sv
// Maze row generator after Eller's method: each request carries the random
// bits for one row plus first-row and last-row flags, and each request yields
// one response with the right and bottom walls of that row.
// The request and response channels use valid and stall; a transfer happens
// on a clock edge with valid high and stall low. The column count is written
// through csr_wr_en and csr_wr_data. The user must write it only while no
// request is in progress; the block itself does not enforce it.
// With n active columns a request is worked on in two passes over the column
// label RAM, one column per cycle: the merge pass and the final relabel and
// bottom-opening pass. A new request is taken only after the previous row
// has been handed to the output register.
// Synchronous reset returns the column count to 32, marks every column as
// walled below, so the next row starts with all columns in their own sets,
// and drops any pending response. The label RAM needs no clearing pass.
// A stalled response is held in the output register while the next request
// is already being worked on; that request waits at its end only while the
// output register still holds a stalled response.
module eller_maze_row_generator import emrg_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_new_maze,
   input  logic               req_last_row,
   input  logic [WALL_W-1:0]  req_wall_bits,
   input  logic [FIELD_W-1:0] req_down_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_right_walls,
   output logic [FIELD_W-1:0] rsp_bottom_walls,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_COLS+1);

   logic [CFG_W-1:0]   csr_cols_ff, csr_cols_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_right_ff, rsp_right_in;
   logic [FIELD_W-1:0] rsp_bottom_ff, rsp_bottom_in;
   logic [CNT_W-1:0]   n_cols;
   logic               busy;
   logic               start;
   logic               res_ready;
   row_result_type     result;

   assign csr_cols_in = csr_wr_en ? csr_wr_data : csr_cols_ff;

   // Column counts outside the supported range are clamped.
   always_comb begin
      if (int'(csr_cols_ff) < MIN_COLS) begin
         n_cols = CNT_W'(MIN_COLS);
      end else if (int'(csr_cols_ff) > MAX_COLS) begin
         n_cols = CNT_W'(MAX_COLS);
      end else begin
         n_cols = CNT_W'(csr_cols_ff);
      end
   end

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   emrg_seq #(
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .new_maze  (req_new_maze),
      .last_row  (req_last_row),
      .wall_bits (req_wall_bits[MAX_COLS-2:0]),
      .down_bits (req_down_bits[MAX_COLS-1:0]),
      .n_cols    (n_cols),
      .res_ready (res_ready),
      .busy      (busy),
      .result    (result)
   );

   always_comb begin
      rsp_right_in  = rsp_right_ff;
      rsp_bottom_in = rsp_bottom_ff;
      if (result.done) begin
         rsp_valid_in  = 1'b1;
         rsp_right_in  = result.right_walls;
         rsp_bottom_in = result.bottom_walls;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cols_ff  <= CFG_W'(COLS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_cols_ff  <= csr_cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_right_ff  <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_right_walls  = rsp_right_ff;
   assign rsp_bottom_walls = rsp_bottom_ff;

endmodule

>>> src/emrg_checker.sv
module emrg_checker import emrg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FIELD_W-1:0] rsp_right_walls,
   input logic [FIELD_W-1:0] rsp_bottom_walls
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_right_walls) && $stable(rsp_bottom_walls))
      else $error("stalled response changed or dropped");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after taking a request");

   a_rightmost_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_walls != '0))
      else $error("row has no rightmost wall");

   // Bottom walls never reach beyond the rightmost column's wall.
   a_bottom_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_bottom_walls} < {rsp_right_walls, 1'b0}))
      else $error("bottom wall beyond the last active column");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a request in progress");

endmodule

bind eller_maze_row_generator emrg_checker u_emrg_checker (.*);
